[hdl/frame_record_playback_controller_macros.svh]
// Assertion helpers for the frame record/playback controller.
`ifndef FRAME_RECORD_PLAYBACK_CONTROLLER_MACROS_SVH
`define FRAME_RECORD_PLAYBACK_CONTROLLER_MACROS_SVH

// Check a property on every clock edge outside reset.
`define FRPC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check that a condition is followed by a result in the next cycle.
`define FRPC_ASSERT_NEXT(label, cond, nxt, msg) \
   `FRPC_ASSERT(label, (cond) |=> (nxt), msg)

`endif

[hdl/frpc_pkg.sv]
`timescale 1ns / 1ps

package frpc_pkg;

   // Default sizing
   localparam int unsigned MAX_FRAMES_DEF = 4096;
   localparam int unsigned CHANNELS_DEF   = 5;

   // Fixed field widths
   localparam int unsigned NUM_CAP   = 5;
   localparam int unsigned SAMPLE_W  = 16;
   localparam int unsigned OP_W      = 3;
   localparam int unsigned POS_OUT_W = 13;

   // Item opcodes
   localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
   localparam logic [OP_W-1:0] OP_REC_START  = 3'd1;
   localparam logic [OP_W-1:0] OP_REC_STOP   = 3'd2;
   localparam logic [OP_W-1:0] OP_PLAY_START = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOP_EN    = 3'd4;

   typedef enum logic [1:0] {
      MODE_THRU = 2'd0,
      MODE_REC  = 2'd1,
      MODE_PLAY = 2'd2
   } mode_type;

   // Source of the held frame after an item
   typedef enum logic [1:0] {
      SEL_HOLD    = 2'd0,
      SEL_CAPTURE = 2'd1,
      SEL_RAM     = 2'd2
   } sel_type;

   typedef struct packed {
      sel_type  sel;
      mode_type mode;
      logic     driven;
      logic     limit;
   } status_type;

endpackage

[hdl/frpc_ram.sv]
`timescale 1ns / 1ps

module frpc_ram #(
   parameter int unsigned WIDTH = 16,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AddrW-1:0] rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/frame_record_playback_controller.sv]
`timescale 1ns / 1ps

// Frame record/playback controller. Takes one item per clock cycle, back to back,
// while the result side keeps up, and presents one result per item, in order: the
// registered read of the frame store and the read stage load at acceptance, and the
// output register loads when the read stage advances. The store holds one
// row of all channel widths per frame in a single memory with one write and one read
// port; a record tick writes its row at acceptance and a playback tick reads its row
// at acceptance, so any frame written is readable by the very next item. The store
// is not cleared after reset, and playback only reaches frames that were recorded.
// rsp_drive_ch* hold the last driven frame between ticks; unused channels read zero.
module frame_record_playback_controller
   import frpc_pkg::*;
#(
   parameter int unsigned MAX_FRAMES = MAX_FRAMES_DEF,
   parameter int unsigned CHANNELS   = CHANNELS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SAMPLE_W-1:0]  req_cap_ch0,
   input  logic [SAMPLE_W-1:0]  req_cap_ch1,
   input  logic [SAMPLE_W-1:0]  req_cap_ch2,
   input  logic [SAMPLE_W-1:0]  req_cap_ch3,
   input  logic [SAMPLE_W-1:0]  req_cap_ch4,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [SAMPLE_W-1:0]  rsp_drive_ch0,
   output logic [SAMPLE_W-1:0]  rsp_drive_ch1,
   output logic [SAMPLE_W-1:0]  rsp_drive_ch2,
   output logic [SAMPLE_W-1:0]  rsp_drive_ch3,
   output logic [SAMPLE_W-1:0]  rsp_drive_ch4,
   output logic                 rsp_frame_driven,
   output logic [1:0]           rsp_mode_now,
   output logic [POS_OUT_W-1:0] rsp_frame_position,
   output logic [POS_OUT_W-1:0] rsp_frames_recorded,
   output logic                 rsp_limit_hit
);

`include "frame_record_playback_controller_macros.svh"

   localparam int unsigned Lanes  = (CHANNELS < NUM_CAP) ? CHANNELS : NUM_CAP;
   localparam int unsigned RowW   = Lanes * SAMPLE_W;
   localparam int unsigned AddrW  = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int unsigned PosW   = $clog2(MAX_FRAMES + 1);
   localparam int unsigned ExtW   = PosW + POS_OUT_W;
   localparam logic [PosW-1:0] MaxPos = PosW'(MAX_FRAMES);

   // Architectural state
   mode_type           mode_ff, mode_in;
   logic               loop_ff, loop_in;
   logic [PosW-1:0]    pos_ff, pos_in;
   logic [PosW-1:0]    rec_ff, rec_in;

   // Read stage
   logic               s1_valid_ff, s1_valid_in;
   status_type         s1_status_ff, status_in;
   logic [PosW-1:0]    s1_pos_ff;
   logic [PosW-1:0]    s1_rec_ff;
   logic [SAMPLE_W-1:0] s1_cap_ff [Lanes];

   // Output register; drive_ff doubles as the held frame
   logic               rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_W-1:0] drive_ff [Lanes];
   logic               driven_ff;
   mode_type           rsp_mode_ff;
   logic [PosW-1:0]    rsp_pos_ff;
   logic [PosW-1:0]    rsp_rec_ff;
   logic               limit_ff;

   logic               accept;
   logic               advance;
   logic               wr_en;
   logic               rd_en;
   logic [PosW-1:0]    pos_inc;
   logic [RowW-1:0]    wr_row;
   logic [RowW-1:0]    rd_row;
   logic [SAMPLE_W-1:0] cap_arr [NUM_CAP];
   logic [SAMPLE_W-1:0] drive_arr [NUM_CAP];
   logic [ExtW-1:0]    pos_ext;
   logic [ExtW-1:0]    rec_ext;

   assign cap_arr[0] = req_cap_ch0;
   assign cap_arr[1] = req_cap_ch1;
   assign cap_arr[2] = req_cap_ch2;
   assign cap_arr[3] = req_cap_ch3;
   assign cap_arr[4] = req_cap_ch4;

   // Handshake: accept while the read stage is empty or moving on
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready    = !s1_valid_ff || advance;
   assign accept       = req_valid && req_ready;
   assign s1_valid_in  = accept || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   assign pos_inc      = pos_ff + 1'b1;

   // Decode the item and update mode, position and count
   always_comb begin
      mode_in          = mode_ff;
      loop_in          = loop_ff;
      pos_in           = pos_ff;
      rec_in           = rec_ff;
      wr_en            = 1'b0;
      rd_en            = 1'b0;
      status_in.sel    = SEL_HOLD;
      status_in.driven = 1'b0;
      status_in.limit  = 1'b0;
      if (accept) begin
         case (req_op)
            OP_TICK: begin
               case (mode_ff)
                  MODE_THRU: begin
                     status_in.sel    = SEL_CAPTURE;
                     status_in.driven = 1'b1;
                  end
                  MODE_REC: begin
                     status_in.sel    = SEL_CAPTURE;
                     status_in.driven = 1'b1;
                     wr_en            = (pos_ff < MaxPos);
                     pos_in           = pos_inc;
                     if (pos_inc >= MaxPos) begin
                        mode_in         = MODE_THRU;
                        rec_in          = pos_inc;
                        status_in.limit = 1'b1;
                     end
                  end
                  MODE_PLAY: begin
                     if (pos_ff >= rec_ff || pos_ff >= MaxPos) begin
                        // empty or finished recording: drop back without a frame
                        mode_in = MODE_THRU;
                     end else begin
                        rd_en            = 1'b1;
                        status_in.sel    = SEL_RAM;
                        status_in.driven = 1'b1;
                        pos_in           = pos_inc;
                        if (pos_inc >= rec_ff) begin
                           if (loop_ff) begin
                              pos_in = '0;
                           end else begin
                              mode_in = MODE_THRU;
                           end
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            OP_REC_START: begin
               pos_in  = '0;
               mode_in = MODE_REC;
            end
            OP_REC_STOP: begin
               mode_in = MODE_THRU;
               rec_in  = pos_ff;
            end
            OP_PLAY_START: begin
               if (mode_ff == MODE_REC) begin
                  rec_in = pos_ff;
               end
               loop_in = 1'b0;
               pos_in  = '0;
               mode_in = MODE_PLAY;
            end
            OP_LOOP_EN: begin
               loop_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
      status_in.mode = mode_in;
   end

   // Pack the captured widths into one store row
   for (genvar g = 0; g < Lanes; g++) begin : g_row
      assign wr_row[g*SAMPLE_W +: SAMPLE_W] = cap_arr[g];
   end

   frpc_ram #(
      .WIDTH (RowW),
      .DEPTH (MAX_FRAMES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (pos_ff[AddrW-1:0]),
      .wr_data (wr_row),
      .rd_en   (rd_en),
      .rd_addr (pos_ff[AddrW-1:0]),
      .rd_data (rd_row)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_THRU;
         loop_ff      <= 1'b0;
         pos_ff       <= '0;
         rec_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         loop_ff      <= loop_in;
         pos_ff       <= pos_in;
         rec_ff       <= rec_in;
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read stage payload: capture on accept
   always_ff @(posedge clock) begin
      if (accept) begin
         s1_status_ff <= status_in;
         s1_pos_ff    <= pos_in;
         s1_rec_ff    <= rec_in;
         for (int i = 0; i < Lanes; i++) begin
            s1_cap_ff[i] <= cap_arr[i];
         end
      end
   end

   // Output register: pick the new held frame on advance
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < Lanes; i++) begin
            drive_ff[i] <= '0;
         end
      end else if (advance) begin
         for (int i = 0; i < Lanes; i++) begin
            case (s1_status_ff.sel)
               SEL_CAPTURE: drive_ff[i] <= s1_cap_ff[i];
               SEL_RAM:     drive_ff[i] <= rd_row[i*SAMPLE_W +: SAMPLE_W];
               default:     drive_ff[i] <= drive_ff[i];
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         driven_ff   <= s1_status_ff.driven;
         rsp_mode_ff <= s1_status_ff.mode;
         limit_ff    <= s1_status_ff.limit;
         rsp_pos_ff  <= s1_pos_ff;
         rsp_rec_ff  <= s1_rec_ff;
      end
   end

   // Drive the result ports; channels past the configured count read zero
   for (genvar g = 0; g < NUM_CAP; g++) begin : g_drive
      if (g < Lanes) begin : g_used
         assign drive_arr[g] = drive_ff[g];
      end else begin : g_unused
         assign drive_arr[g] = '0;
      end
   end

   assign pos_ext = {{POS_OUT_W{1'b0}}, rsp_pos_ff};
   assign rec_ext = {{POS_OUT_W{1'b0}}, rsp_rec_ff};

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_drive_ch0       = drive_arr[0];
   assign rsp_drive_ch1       = drive_arr[1];
   assign rsp_drive_ch2       = drive_arr[2];
   assign rsp_drive_ch3       = drive_arr[3];
   assign rsp_drive_ch4       = drive_arr[4];
   assign rsp_frame_driven    = driven_ff;
   assign rsp_mode_now        = rsp_mode_ff;
   assign rsp_frame_position  = pos_ext[POS_OUT_W-1:0];
   assign rsp_frames_recorded = rec_ext[POS_OUT_W-1:0];
   assign rsp_limit_hit       = limit_ff;

   // Checks
   `FRPC_ASSERT(a_pos_bound, pos_ff <= MaxPos, "position beyond store size")
   `FRPC_ASSERT(a_rec_bound, rec_ff <= MaxPos, "recorded count beyond store size")
   `FRPC_ASSERT(a_record_room, mode_ff == MODE_REC |-> pos_ff < MaxPos, "record with full store")
   `FRPC_ASSERT_NEXT(a_read_lands, rd_en, s1_valid_ff && s1_status_ff.sel == SEL_RAM, "store read lost")
   `FRPC_ASSERT(a_limit_mode, rsp_valid_ff && limit_ff |-> rsp_mode_ff == MODE_THRU && rsp_pos_ff == rsp_rec_ff, "limit without stop")

endmodule

[tb/frame_playback_checker.sv]
`timescale 1ns / 1ps

// Watches the request and result sides of the record/playback controller, predicts each result
// from the accepted items and compares it field by field, in order.
module frame_playback_checker
   import frpc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic [OP_W-1:0]      req_op,
   input  logic [SAMPLE_W-1:0]  req_cap_ch0,
   input  logic [SAMPLE_W-1:0]  req_cap_ch1,
   input  logic [SAMPLE_W-1:0]  req_cap_ch2,
   input  logic [SAMPLE_W-1:0]  req_cap_ch3,
   input  logic [SAMPLE_W-1:0]  req_cap_ch4,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [SAMPLE_W-1:0]  rsp_drive_ch0,
   input  logic [SAMPLE_W-1:0]  rsp_drive_ch1,
   input  logic [SAMPLE_W-1:0]  rsp_drive_ch2,
   input  logic [SAMPLE_W-1:0]  rsp_drive_ch3,
   input  logic [SAMPLE_W-1:0]  rsp_drive_ch4,
   input  logic                 rsp_frame_driven,
   input  logic [1:0]           rsp_mode_now,
   input  logic [POS_OUT_W-1:0] rsp_frame_position,
   input  logic [POS_OUT_W-1:0] rsp_frames_recorded,
   input  logic                 rsp_limit_hit,
   output int                   errors,
   output int                   outstanding,
   output int                   ticks_seen,
   output int                   frames_played,
   output int                   wraps_seen,
   output int                   limit_stops
);

   typedef logic [NUM_CAP-1:0][SAMPLE_W-1:0] width_set_type;

   typedef struct {
      width_set_type        drive;
      logic                 driven;
      logic [1:0]           mode;
      logic [POS_OUT_W-1:0] pos;
      logic [POS_OUT_W-1:0] count;
      logic                 limit;
   } frame_result_type;

   // Shadow state of the controller
   mode_type      mode_q;
   logic          loop_q;
   int unsigned   pos_q;
   int unsigned   count_q;
   width_set_type held_q;
   width_set_type frame_mem [MAX_FRAMES_DEF];

   frame_result_type pending_results [$];

   int err_count    = 0;
   int tick_count   = 0;
   int played_count = 0;
   int wrap_count   = 0;
   int limit_count  = 0;

   // Advance the shadow state by one item and return the result it causes.
   function automatic frame_result_type apply_item(input logic [OP_W-1:0] op,
                                                   input width_set_type caps);
      frame_result_type r;
      r.driven = 1'b0;
      r.limit  = 1'b0;
      case (op)
         OP_TICK: begin
            tick_count++;
            if (mode_q != MODE_PLAY) begin
               held_q   = caps;
               r.driven = 1'b1;
            end
            if (mode_q == MODE_REC) begin
               // store the frame, stop when the store is full
               if (pos_q < MAX_FRAMES_DEF)
                  frame_mem[pos_q] = held_q;
               pos_q++;
               if (pos_q >= MAX_FRAMES_DEF) begin
                  mode_q  = MODE_THRU;
                  count_q = pos_q;
                  r.limit = 1'b1;
                  limit_count++;
               end
            end else if (mode_q == MODE_PLAY) begin
               if (pos_q >= count_q || pos_q >= MAX_FRAMES_DEF) begin
                  // nothing left to play: drop back to bypass, hold the outputs
                  mode_q = MODE_THRU;
               end else begin
                  held_q   = frame_mem[pos_q];
                  r.driven = 1'b1;
                  played_count++;
                  pos_q++;
                  if (pos_q >= count_q) begin
                     if (!loop_q) begin
                        mode_q = MODE_THRU;
                     end else begin
                        pos_q = 0;
                        wrap_count++;
                     end
                  end
               end
            end
         end
         OP_REC_START: begin
            pos_q  = 0;
            mode_q = MODE_REC;
         end
         OP_REC_STOP: begin
            mode_q  = MODE_THRU;
            count_q = pos_q;
         end
         OP_PLAY_START: begin
            if (mode_q == MODE_REC)
               count_q = pos_q;
            loop_q = 1'b0;
            pos_q  = 0;
            mode_q = MODE_PLAY;
         end
         OP_LOOP_EN: begin
            loop_q = 1'b1;
         end
         default: ;
      endcase
      r.drive = held_q;
      r.mode  = mode_q;
      r.pos   = pos_q[POS_OUT_W-1:0];
      r.count = count_q[POS_OUT_W-1:0];
      return r;
   endfunction

   task automatic check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         err_count++;
      end
   endtask

   always @(posedge clock) begin
      frame_result_type want;
      width_set_type    caps;
      width_set_type    got_drive;
      if (reset) begin
         mode_q  = MODE_THRU;
         loop_q  = 1'b0;
         pos_q   = 0;
         count_q = 0;
         held_q  = '0;
         pending_results.delete();
      end else begin
         // predict first, so a result in the same cycle always finds its item
         if (req_valid && req_ready) begin
            caps = {req_cap_ch4, req_cap_ch3, req_cap_ch2, req_cap_ch1, req_cap_ch0};
            pending_results.push_back(apply_item(req_op, caps));
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_results.size() == 0) begin
               $error("result arrived with no item pending");
               err_count++;
            end else begin
               want      = pending_results.pop_front();
               got_drive = {rsp_drive_ch4, rsp_drive_ch3, rsp_drive_ch2,
                            rsp_drive_ch1, rsp_drive_ch0};
               for (int c = 0; c < NUM_CAP; c++)
                  check_field($sformatf("drive_ch%0d", c), want.drive[c], got_drive[c]);
               check_field("frame_driven", want.driven, rsp_frame_driven);
               check_field("mode_now", want.mode, rsp_mode_now);
               check_field("frame_position", want.pos, rsp_frame_position);
               check_field("frames_recorded", want.count, rsp_frames_recorded);
               check_field("limit_hit", want.limit, rsp_limit_hit);
            end
         end
      end
      // publish counters
      errors        <= err_count;
      outstanding   <= pending_results.size();
      ticks_seen    <= tick_count;
      frames_played <= played_count;
      wraps_seen    <= wrap_count;
      limit_stops   <= limit_count;
   end

endmodule

[tb/tb_frame_record_playback_controller.sv]
`timescale 1ns / 1ps

module tb_frame_record_playback_controller;
   import frpc_pkg::*;

   typedef logic [NUM_CAP-1:0][SAMPLE_W-1:0] width_set_type;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic [OP_W-1:0]      req_op;
   logic [SAMPLE_W-1:0]  req_cap_ch0;
   logic [SAMPLE_W-1:0]  req_cap_ch1;
   logic [SAMPLE_W-1:0]  req_cap_ch2;
   logic [SAMPLE_W-1:0]  req_cap_ch3;
   logic [SAMPLE_W-1:0]  req_cap_ch4;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [SAMPLE_W-1:0]  rsp_drive_ch0;
   logic [SAMPLE_W-1:0]  rsp_drive_ch1;
   logic [SAMPLE_W-1:0]  rsp_drive_ch2;
   logic [SAMPLE_W-1:0]  rsp_drive_ch3;
   logic [SAMPLE_W-1:0]  rsp_drive_ch4;
   logic                 rsp_frame_driven;
   logic [1:0]           rsp_mode_now;
   logic [POS_OUT_W-1:0] rsp_frame_position;
   logic [POS_OUT_W-1:0] rsp_frames_recorded;
   logic                 rsp_limit_hit;

   int errors;
   int outstanding;
   int ticks_seen;
   int frames_played;
   int wraps_seen;
   int limit_stops;

   // Idle rates in percent, and the one long receiver hold-off
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   bit hold_off_req = 1'b0;
   int busy_items   = 0;

   frame_record_playback_controller DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_cap_ch0         (req_cap_ch0),
      .req_cap_ch1         (req_cap_ch1),
      .req_cap_ch2         (req_cap_ch2),
      .req_cap_ch3         (req_cap_ch3),
      .req_cap_ch4         (req_cap_ch4),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_ch0       (rsp_drive_ch0),
      .rsp_drive_ch1       (rsp_drive_ch1),
      .rsp_drive_ch2       (rsp_drive_ch2),
      .rsp_drive_ch3       (rsp_drive_ch3),
      .rsp_drive_ch4       (rsp_drive_ch4),
      .rsp_frame_driven    (rsp_frame_driven),
      .rsp_mode_now        (rsp_mode_now),
      .rsp_frame_position  (rsp_frame_position),
      .rsp_frames_recorded (rsp_frames_recorded),
      .rsp_limit_hit       (rsp_limit_hit)
   );

   frame_playback_checker checker_inst (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_op              (req_op),
      .req_cap_ch0         (req_cap_ch0),
      .req_cap_ch1         (req_cap_ch1),
      .req_cap_ch2         (req_cap_ch2),
      .req_cap_ch3         (req_cap_ch3),
      .req_cap_ch4         (req_cap_ch4),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_drive_ch0       (rsp_drive_ch0),
      .rsp_drive_ch1       (rsp_drive_ch1),
      .rsp_drive_ch2       (rsp_drive_ch2),
      .rsp_drive_ch3       (rsp_drive_ch3),
      .rsp_drive_ch4       (rsp_drive_ch4),
      .rsp_frame_driven    (rsp_frame_driven),
      .rsp_mode_now        (rsp_mode_now),
      .rsp_frame_position  (rsp_frame_position),
      .rsp_frames_recorded (rsp_frames_recorded),
      .rsp_limit_hit       (rsp_limit_hit),
      .errors              (errors),
      .outstanding         (outstanding),
      .ticks_seen          (ticks_seen),
      .frames_played       (frames_played),
      .wraps_seen          (wraps_seen),
      .limit_stops         (limit_stops)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs
   initial begin
      #10_000_000;
      $display("[frame_record_playback_controller] ERROR");
      $finish;
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_req) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
            hold_off_req = 1'b0;
         end else if ($urandom_range(0, 99) < rx_idle_pct) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   function automatic width_set_type random_widths();
      width_set_type w;
      for (int c = 0; c < NUM_CAP; c++) begin
         case ($urandom_range(0, 7))
            0:       w[c] = '0;
            1:       w[c] = '1;
            default: w[c] = SAMPLE_W'($urandom_range(0, 65535));
         endcase
      end
      return w;
   endfunction

   function automatic width_set_type uniform_widths(input logic [SAMPLE_W-1:0] v);
      return {NUM_CAP{v}};
   endfunction

   // Offer one item, with an optional idle burst first; return once it is taken.
   task automatic offer_item(input logic [OP_W-1:0] op, input width_set_type w);
      bit taken;
      if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_op      <= op;
      req_cap_ch0 <= w[0];
      req_cap_ch1 <= w[1];
      req_cap_ch2 <= w[2];
      req_cap_ch3 <= w[3];
      req_cap_ch4 <= w[4];
      // sample ready mid-cycle, when everything has settled
      do begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end while (!taken);
      if (op <= OP_LOOP_EN)
         busy_items++;
   endtask

   task automatic offer_op(input logic [OP_W-1:0] op);
      offer_item(op, random_widths());
   endtask

   // One random stretch: mostly a recording followed by playback, some bypass
   // traffic, and some unstructured noise including the unused opcodes.
   task automatic run_session();
      int kind;
      int n;
      int m;
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
         n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 120) : $urandom_range(0, 16);
         offer_op(OP_REC_START);
         repeat (n) offer_item(OP_TICK, random_widths());
         if ($urandom_range(0, 2) != 0)
            offer_op(OP_REC_STOP);
         offer_op(OP_PLAY_START);
         if ($urandom_range(0, 1))
            offer_op(OP_LOOP_EN);
         m = $urandom_range(0, 2 * n + 4);
         repeat (m) begin
            if ($urandom_range(0, 40) == 0)
               offer_op(OP_LOOP_EN + OP_W'($urandom_range(0, 3)) - OP_W'(2));
            else
               offer_item(OP_TICK, random_widths());
         end
      end else if (kind < 8) begin
         repeat ($urandom_range(1, 8)) offer_item(OP_TICK, random_widths());
      end else begin
         repeat ($urandom_range(1, 6)) offer_op(OP_W'($urandom_range(0, 7)));
      end
   endtask

   initial begin
      int target;
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_op      <= OP_TICK;
      req_cap_ch0 <= '0;
      req_cap_ch1 <= '0;
      req_cap_ch2 <= '0;
      req_cap_ch3 <= '0;
      req_cap_ch4 <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: extremes of the widths and the unused opcodes
      offer_item(OP_TICK, uniform_widths('0));
      offer_item(OP_TICK, uniform_widths('1));
      offer_op(OP_LOOP_EN + OP_W'(1));
      offer_op(OP_LOOP_EN + OP_W'(2));
      offer_op(OP_LOOP_EN + OP_W'(3));
      // playback of an empty recording falls back to bypass
      offer_op(OP_PLAY_START);
      offer_item(OP_TICK, random_widths());
      // stop record while in bypass
      offer_op(OP_REC_STOP);
      // restart a recording midway, then stop it
      offer_op(OP_REC_START);
      offer_item(OP_TICK, uniform_widths(16'h0001));
      offer_op(OP_REC_START);
      offer_item(OP_TICK, uniform_widths(16'h8000));
      offer_item(OP_TICK, uniform_widths(16'h7FFF));
      offer_op(OP_REC_STOP);
      // start playback clears looping: play out and return to bypass
      offer_op(OP_LOOP_EN);
      offer_op(OP_PLAY_START);
      repeat (3) offer_item(OP_TICK, random_widths());
      // looping playback wraps, then stop record in playback
      offer_op(OP_PLAY_START);
      offer_op(OP_LOOP_EN);
      repeat (5) offer_item(OP_TICK, random_widths());
      offer_op(OP_REC_STOP);
      // start playback ends a running recording
      offer_op(OP_REC_START);
      offer_item(OP_TICK, random_widths());
      offer_op(OP_PLAY_START);
      offer_item(OP_TICK, random_widths());

      // Fill the whole store while the result side holds off for a while
      rx_idle_pct  = 20;
      hold_off_req = 1'b1;
      offer_op(OP_REC_START);
      repeat (MAX_FRAMES_DEF) offer_item(OP_TICK, random_widths());
      offer_item(OP_TICK, random_widths());
      offer_op(OP_PLAY_START);
      offer_op(OP_LOOP_EN);
      repeat (40) offer_item(OP_TICK, random_widths());
      offer_op(OP_REC_STOP);

      // Random sessions; the tail runs with no idling at all
      target = busy_items + 1900;
      while (busy_items < target) begin
         if (target - busy_items < 200) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end else begin
            tx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
            rx_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 60);
         end
         run_session();
      end
      req_valid <= 1'b0;

      // Drain: wait for every result, then let any stray result show up
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Covered %0d items: %0d ticks, %0d frames played back, %0d loop wraps,",
               busy_items, ticks_seen, frames_played, wraps_seen);
      $display("%0d store-full stops, empty playback and command cases under random stalls.",
               limit_stops);
      if (errors == 0) begin
         $display("[frame_record_playback_controller] OK");
      end else begin
         $display("[frame_record_playback_controller] ERROR");
      end
      $finish;
   end

endmodule
